[rtl/core/b8usp_pkg.sv]
`default_nettype none
package b8usp_pkg;

  // Option byte bits
  localparam logic [7:0] OPT_BYTE_WIDE = 8'h01;
  localparam logic [7:0] OPT_BYTE_PHON = 8'h04;
  localparam logic [7:0] OPT_BYTE_RICH = 8'h08;

  // Packed option flags kept in state
  localparam int OPT_WIDE_BIT = 0;
  localparam int OPT_PHON_BIT = 1;
  localparam int OPT_RICH_BIT = 2;

  // Count prefix width selector
  localparam logic [1:0] LFB_ONE_BYTE = 2'd1;
  localparam logic [1:0] LFB_RESET    = 2'd2;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CNT_HI = 4'd1,
    PH_OPTS   = 4'd2,
    PH_RT_LO  = 4'd3,
    PH_RT_HI  = 4'd4,
    PH_SZ     = 4'd5,
    PH_CH_LO  = 4'd6,
    PH_CH_HI  = 4'd7,
    PH_RUNS   = 4'd8,
    PH_PHON   = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_string;
    logic        length_known;
    logic [15:0] known_length;
    logic        end_of_data;
  } in_word_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic        has_char;
    logic        last;
    logic [31:0] field_bytes;
  } res_t;

  typedef struct packed {
    phase_t ph;
    logic   done;
  } tail_t;

  // Pick the phase after the header or a finished section: characters,
  // then run skip, then phonetic skip, else the field is complete.
  function automatic tail_t enter_tail(input logic chars_nz, input logic run_nz,
                                       input logic phon_nz);
    tail_t t;
    t.done = 1'b0;
    if (chars_nz)      t.ph = PH_CH_LO;
    else if (run_nz)   t.ph = PH_RUNS;
    else if (phon_nz)  t.ph = PH_PHON;
    else begin
      t.ph   = PH_IDLE;
      t.done = 1'b1;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/core/b8usp_core.sv]
`default_nettype none
module b8usp_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire b8usp_pkg::in_word_t word,
  input  wire logic [1:0]         lfb,
  output b8usp_pkg::res_t         res
);
  import b8usp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] chars_r, chars_nxt;
  logic [2:0]  opt_r, opt_nxt;
  logic [17:0] run_r, run_nxt;
  logic [31:0] phon_r, phon_nxt;
  logic [31:0] bc_r, bc_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [1:0]  fbi_r, fbi_nxt;

  // Working copies: a start with known length clears the field and enters options
  phase_t      ph_w;
  logic [15:0] chars_w;
  logic [2:0]  opt_w;
  logic [17:0] run_w;
  logic [31:0] phon_w;
  logic [31:0] bc_w;
  logic [7:0]  low_w;
  logic [1:0]  fbi_w;

  assign ph_w    = word.start_of_string ? PH_OPTS : phase_r;
  assign chars_w = word.start_of_string ? word.known_length : chars_r;
  assign opt_w   = word.start_of_string ? 3'd0 : opt_r;
  assign run_w   = word.start_of_string ? 18'd0 : run_r;
  assign phon_w  = word.start_of_string ? 32'd0 : phon_r;
  assign bc_w    = word.start_of_string ? 32'd0 : bc_r;
  assign low_w   = word.start_of_string ? 8'd0 : low_r;
  assign fbi_w   = word.start_of_string ? 2'd0 : fbi_r;

  // Next state and result for one byte
  always_comb begin
    tail_t       t;
    logic [15:0] cnt;
    logic [15:0] ch_dec;
    logic [17:0] run_dec;
    logic [31:0] phon_dec;
    logic [31:0] phon_or;
    logic [2:0]  flags;
    logic        eod;
    logic [7:0]  b;
    b         = word.data_byte;
    eod       = word.end_of_data;
    cnt       = {b, low_w};
    ch_dec    = chars_w - 16'd1;
    run_dec   = run_w - 18'd1;
    phon_dec  = phon_w - 32'd1;
    phon_or   = phon_w | ({24'd0, b} << {fbi_w, 3'b000});
    flags     = {(b & OPT_BYTE_RICH) != 8'd0, (b & OPT_BYTE_PHON) != 8'd0,
                 (b & OPT_BYTE_WIDE) != 8'd0};
    t         = '0;
    phase_nxt = ph_w;
    chars_nxt = chars_w;
    opt_nxt   = opt_w;
    run_nxt   = run_w;
    phon_nxt  = phon_w;
    bc_nxt    = bc_w + 32'd1;
    low_nxt   = low_w;
    fbi_nxt   = fbi_w;
    res       = '0;

    if (word.start_of_string && !word.length_known) begin
      // First byte of a counted field
      bc_nxt = 32'd1;
      if (lfb == LFB_ONE_BYTE) begin
        chars_nxt = {8'd0, b};
        if (b == 8'd0 && eod) begin
          phase_nxt = PH_IDLE;
          res.emit  = 1'b1;
          res.last  = 1'b1;
        end else begin
          phase_nxt = PH_OPTS;
        end
      end else begin
        low_nxt   = b;
        phase_nxt = PH_CNT_HI;
      end
    end else begin
      unique case (ph_w)
        PH_CNT_HI: begin
          chars_nxt = cnt;
          if (cnt == 16'd0 && eod) begin
            phase_nxt = PH_IDLE;
            res.emit  = 1'b1;
            res.last  = 1'b1;
          end else begin
            phase_nxt = PH_OPTS;
          end
        end
        PH_OPTS: begin
          if (chars_w == 16'd0 && eod) begin
            // Empty field: the would-be options byte is not counted
            bc_nxt    = bc_w;
            phase_nxt = PH_IDLE;
            res.emit  = 1'b1;
            res.last  = 1'b1;
          end else begin
            opt_nxt = flags;
            if (flags[OPT_RICH_BIT]) begin
              phase_nxt = PH_RT_LO;
            end else if (flags[OPT_PHON_BIT]) begin
              phase_nxt = PH_SZ;
              fbi_nxt   = 2'd0;
            end else begin
              t = enter_tail(chars_w != 16'd0, run_w != 18'd0, phon_w != 32'd0);
              phase_nxt = t.ph;
              res.emit  = t.done;
              res.last  = t.done;
            end
          end
        end
        PH_RT_LO: begin
          low_nxt   = b;
          phase_nxt = PH_RT_HI;
        end
        PH_RT_HI: begin
          run_nxt = {cnt, 2'b00};
          if (opt_w[OPT_PHON_BIT]) begin
            phase_nxt = PH_SZ;
            fbi_nxt   = 2'd0;
          end else begin
            t = enter_tail(chars_w != 16'd0, cnt != 16'd0, phon_w != 32'd0);
            phase_nxt = t.ph;
            res.emit  = t.done;
            res.last  = t.done;
          end
        end
        PH_SZ: begin
          if (fbi_w == 2'd3) begin
            // Clamp a negative phonetic size to zero
            phon_nxt = phon_or[31] ? 32'd0 : phon_or;
            fbi_nxt  = 2'd0;
            t = enter_tail(chars_w != 16'd0, run_w != 18'd0,
                           !phon_or[31] && phon_or != 32'd0);
            phase_nxt = t.ph;
            res.emit  = t.done;
            res.last  = t.done;
          end else begin
            phon_nxt = phon_or;
            fbi_nxt  = fbi_w + 2'd1;
          end
        end
        PH_CH_LO: begin
          if (opt_w[OPT_WIDE_BIT]) begin
            low_nxt   = b;
            phase_nxt = PH_CH_HI;
          end else begin
            // Latin-1 byte widened to one code unit
            chars_nxt = ch_dec;
            if (ch_dec == 16'd0) begin
              t = enter_tail(1'b0, run_w != 18'd0, phon_w != 32'd0);
              phase_nxt = t.ph;
            end
            res.emit      = 1'b1;
            res.has_char  = 1'b1;
            res.code_unit = {8'd0, b};
            res.last      = t.done;
          end
        end
        PH_CH_HI: begin
          chars_nxt = ch_dec;
          if (ch_dec == 16'd0) begin
            t = enter_tail(1'b0, run_w != 18'd0, phon_w != 32'd0);
            phase_nxt = t.ph;
          end else begin
            phase_nxt = PH_CH_LO;
          end
          res.emit      = 1'b1;
          res.has_char  = 1'b1;
          res.code_unit = cnt;
          res.last      = t.done;
        end
        PH_RUNS: begin
          run_nxt = run_dec;
          if (run_dec == 18'd0) begin
            t = enter_tail(1'b0, 1'b0, phon_w != 32'd0);
            phase_nxt = t.ph;
            res.emit  = t.done;
            res.last  = t.done;
          end
        end
        PH_PHON: begin
          phon_nxt = phon_dec;
          if (phon_dec == 32'd0) begin
            phase_nxt = PH_IDLE;
            res.emit  = 1'b1;
            res.last  = 1'b1;
          end
        end
        default: begin
          // Idle, or a code that means nothing: drop the byte
          bc_nxt    = bc_w;
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    res.field_bytes = res.last ? bc_nxt : 32'd0;
  end

  // Hold parser state; advance only on a fired word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      chars_r <= '0;
      opt_r   <= '0;
      run_r   <= '0;
      phon_r  <= '0;
      bc_r    <= '0;
      low_r   <= '0;
      fbi_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      chars_r <= chars_nxt;
      opt_r   <= opt_nxt;
      run_r   <= run_nxt;
      phon_r  <= phon_nxt;
      bc_r    <= bc_nxt;
      low_r   <= low_nxt;
      fbi_r   <= fbi_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/biff8_unicode_string_parser_unit.sv]
`default_nettype none
// Spreadsheet Unicode string field parser. Takes one data byte per word and
// returns at most one result word per input byte: a decoded character, or an
// empty word that closes a field; the closing word has tlast set and carries
// the field's byte length. Throughput is one byte per cycle unless the output
// stalls, set by the single pass of parser state logic; bytes pass the input
// register, the parser and the result register. cfg_wr_data selects a one-byte
// count prefix when 1 and a two-byte prefix otherwise; write it only while idle.
module biff8_unicode_string_parser_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [1:0]                      cfg_wr_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // data_byte[7:0], known_length[23:8]
  input  wire logic [b8usp_pkg::IN_TDATA_W-1:0] in_tdata,
  // start_of_string[0], length_known[1]
  input  wire logic [b8usp_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // code_unit[15:0], field_bytes[47:16]
  output logic [b8usp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // has_char[0]
  output logic                                 out_tuser,
  output logic                                 out_tlast
);
  import b8usp_pkg::*;

  logic       lfb_r;
  logic [1:0] lfb_val_r;
  logic       in_valid_r;
  in_word_t   in_data_r;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       step_res;
  logic       advance;
  logic       fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfb_val_r <= LFB_RESET;
      lfb_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      lfb_val_r <= cfg_wr_data;
      lfb_r     <= 1'b1;
    end
  end

  // Input register: load whenever the slot is free or drains this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_data_r.data_byte       <= in_tdata[7:0];
      in_data_r.known_length    <= in_tdata[23:8];
      in_data_r.start_of_string <= in_tuser[0];
      in_data_r.length_known    <= in_tuser[1];
      in_data_r.end_of_data     <= in_tlast;
    end
  end

  b8usp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .word  (in_data_r),
    .lfb   (lfb_val_r),
    .res   (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && step_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.field_bytes, out_res_r.code_unit};
  assign out_tuser  = out_res_r.has_char;
  assign out_tlast  = out_res_r.last;

  // A result without a character must close its field
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.has_char || out_res_r.last))
    else $error("empty result word not marked last");

  // Field length appears only on the closing word
  a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.last) |-> (out_res_r.field_bytes == 32'd0))
    else $error("field length on a non-closing word");

  // A stalled input word stays in place
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_data_r)))
    else $error("input word lost during stall");

  // The prefix width keeps its reset value until the first write
  a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (!lfb_r) |-> (lfb_val_r == LFB_RESET))
    else $error("prefix width changed without a write");

endmodule
`default_nettype wire

[tb/sv/biff8_string_checker.sv]
module biff8_string_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [1:0]                        cfg_wr_data,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  // data_byte[7:0], known_length[23:8]
  input  wire logic [b8usp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // start_of_string[0], length_known[1]
  input  wire logic [b8usp_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                              in_tlast,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  // code_unit[15:0], field_bytes[47:16]
  input  wire logic [b8usp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // has_char[0]
  input  wire logic                              out_tuser,
  input  wire logic                              out_tlast,
  output int                                     fail_count,
  output int                                     backlog,
  output int                                     results_checked
);
  import b8usp_pkg::*;

  // Parser state mirrored from the block
  logic [1:0]  prefix_sel;
  phase_t      ph;
  logic [15:0] chars_left;
  logic [2:0]  opts;
  logic [17:0] run_left;
  logic [31:0] phon_left;
  logic [31:0] nbytes;
  logic [7:0]  lo_hold;
  logic [1:0]  sz_idx;

  // Results still owed by the block, oldest first
  res_t owed_results[$];

  // Next section after a header or a finished section; idle means complete
  function automatic phase_t next_section(input logic chars_nz, input logic runs_nz,
                                          input logic phon_nz);
    if (chars_nz) return PH_CH_LO;
    if (runs_nz)  return PH_RUNS;
    if (phon_nz)  return PH_PHON;
    return PH_IDLE;
  endfunction

  function automatic res_t result_word(input logic [15:0] code, input logic has,
                                       input logic fin, input logic [31:0] total);
    res_t r;
    r.emit        = 1'b1;
    r.code_unit   = has ? code : 16'h0000;
    r.has_char    = has;
    r.last        = fin;
    r.field_bytes = fin ? total : 32'h0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Advance the parser by one byte; r.emit marks a result
  task automatic decode_byte(input in_word_t w, output res_t r);
    logic [7:0] b;
    b = w.data_byte;
    r = '0;
    if (w.start_of_string) begin
      opts      = '0;
      run_left  = '0;
      phon_left = '0;
      nbytes    = '0;
      lo_hold   = '0;
      sz_idx    = '0;
      if (!w.length_known) begin
        nbytes = 32'd1;
        if (prefix_sel == LFB_ONE_BYTE) begin
          chars_left = {8'h00, b};
          if (chars_left == 16'h0 && w.end_of_data) begin
            ph = PH_IDLE;
            r  = result_word(16'h0, 1'b0, 1'b1, nbytes);
          end else begin
            ph = PH_OPTS;
          end
        end else begin
          lo_hold = b;
          ph      = PH_CNT_HI;
        end
        return;
      end
      chars_left = w.known_length;
      ph         = PH_OPTS;
    end

    case (ph)
      PH_CNT_HI: begin
        nbytes++;
        chars_left = {b, lo_hold};
        if (chars_left == 16'h0 && w.end_of_data) begin
          ph = PH_IDLE;
          r  = result_word(16'h0, 1'b0, 1'b1, nbytes);
        end else begin
          ph = PH_OPTS;
        end
      end
      PH_OPTS: begin
        // empty field whose options byte is the end of the data: byte not counted
        if (chars_left == 16'h0 && w.end_of_data) begin
          ph = PH_IDLE;
          r  = result_word(16'h0, 1'b0, 1'b1, nbytes);
        end else begin
          nbytes++;
          opts = '0;
          opts[OPT_WIDE_BIT] = |(b & OPT_BYTE_WIDE);
          opts[OPT_PHON_BIT] = |(b & OPT_BYTE_PHON);
          opts[OPT_RICH_BIT] = |(b & OPT_BYTE_RICH);
          if (opts[OPT_RICH_BIT]) begin
            ph = PH_RT_LO;
          end else if (opts[OPT_PHON_BIT]) begin
            ph     = PH_SZ;
            sz_idx = '0;
          end else begin
            ph = next_section(chars_left != 0, run_left != 0, phon_left != 0);
            if (ph == PH_IDLE) r = result_word(16'h0, 1'b0, 1'b1, nbytes);
          end
        end
      end
      PH_RT_LO: begin
        nbytes++;
        lo_hold = b;
        ph      = PH_RT_HI;
      end
      PH_RT_HI: begin
        nbytes++;
        run_left = {b, lo_hold, 2'b00};
        if (opts[OPT_PHON_BIT]) begin
          ph     = PH_SZ;
          sz_idx = '0;
        end else begin
          ph = next_section(chars_left != 0, run_left != 0, phon_left != 0);
          if (ph == PH_IDLE) r = result_word(16'h0, 1'b0, 1'b1, nbytes);
        end
      end
      PH_SZ: begin
        nbytes++;
        phon_left = phon_left | ({24'h0, b} << (8 * sz_idx));
        if (sz_idx == 2'd3) begin
          sz_idx = '0;
          // negative phonetic size counts as none
          if (phon_left[31]) phon_left = '0;
          ph = next_section(chars_left != 0, run_left != 0, phon_left != 0);
          if (ph == PH_IDLE) r = result_word(16'h0, 1'b0, 1'b1, nbytes);
        end else begin
          sz_idx = sz_idx + 2'd1;
        end
      end
      PH_CH_LO: begin
        nbytes++;
        if (opts[OPT_WIDE_BIT]) begin
          lo_hold = b;
          ph      = PH_CH_HI;
        end else begin
          chars_left = chars_left - 16'd1;
          if (chars_left == 16'h0) ph = next_section(1'b0, run_left != 0, phon_left != 0);
          r = result_word({8'h00, b}, 1'b1, chars_left == 16'h0 && ph == PH_IDLE, nbytes);
        end
      end
      PH_CH_HI: begin
        nbytes++;
        chars_left = chars_left - 16'd1;
        if (chars_left == 16'h0) ph = next_section(1'b0, run_left != 0, phon_left != 0);
        else ph = PH_CH_LO;
        r = result_word({b, lo_hold}, 1'b1, chars_left == 16'h0 && ph == PH_IDLE, nbytes);
      end
      PH_RUNS: begin
        nbytes++;
        run_left = run_left - 18'd1;
        if (run_left == 18'h0) begin
          ph = next_section(1'b0, 1'b0, phon_left != 0);
          if (ph == PH_IDLE) r = result_word(16'h0, 1'b0, 1'b1, nbytes);
        end
      end
      PH_PHON: begin
        nbytes++;
        phon_left = phon_left - 32'd1;
        if (phon_left == 32'h0) begin
          ph = PH_IDLE;
          r  = result_word(16'h0, 1'b0, 1'b1, nbytes);
        end
      end
      default: ph = PH_IDLE;
    endcase
  endtask

  // Predict on each accepted byte, compare each accepted result word
  always @(posedge clk) begin : watch
    in_word_t w;
    res_t     r;
    res_t     want;
    if (!rst_n) begin
      prefix_sel = LFB_RESET;
      ph         = PH_IDLE;
      chars_left = '0;
      opts       = '0;
      run_left   = '0;
      phon_left  = '0;
      nbytes     = '0;
      lo_hold    = '0;
      sz_idx     = '0;
      owed_results.delete();
    end else begin
      if (cfg_wr_en) prefix_sel = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        w.data_byte       = in_tdata[7:0];
        w.known_length    = in_tdata[23:8];
        w.start_of_string = in_tuser[0];
        w.length_known    = in_tuser[1];
        w.end_of_data     = in_tlast;
        decode_byte(w, r);
        if (r.emit) owed_results = {owed_results, r};
      end
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (owed_results.size() == 0) begin
          report_mismatch("result word with none expected", 32'(out_tdata[15:0]), 32'h0);
        end else begin
          want = owed_results.pop_front();
          if (out_tdata[15:0] !== want.code_unit)
            report_mismatch("code_unit", 32'(out_tdata[15:0]), 32'(want.code_unit));
          if (out_tuser !== want.has_char)
            report_mismatch("has_char", 32'(out_tuser), 32'(want.has_char));
          if (out_tlast !== want.last)
            report_mismatch("last", 32'(out_tlast), 32'(want.last));
          if (out_tdata[47:16] !== want.field_bytes)
            report_mismatch("field_bytes", out_tdata[47:16], want.field_bytes);
        end
      end
    end
    backlog = owed_results.size();
  end

endmodule

[tb/sv/biff8_unicode_string_parser_unit_tb.sv]
module biff8_unicode_string_parser_unit_tb;
  import b8usp_pkg::*;

  localparam int CYCLE_LIMIT  = 150000;
  localparam int RANDOM_WORDS = 1320;
  localparam int HOLD_CYCLES  = 400;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [1:0]             cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;
  logic                   in_tlast    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  int  mismatches;
  int  backlog;
  int  results_checked;
  int  cycle_n      = 0;
  int  words_sent   = 0;
  int  field_words  = 0;
  logic steady       = 1'b0;
  logic hold_request = 1'b0;
  logic hold_done    = 1'b0;
  int  hold_left    = 0;
  logic [1:0] prefix_now = LFB_RESET;

  in_word_t field_q[$];

  biff8_unicode_string_parser_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  biff8_string_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .fail_count       (mismatches),
    .backlog          (backlog),
    .results_checked  (results_checked)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles, %0d results owed", cycle_n, backlog);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else if (!steady && $urandom_range(99) < 21) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one word; entered and left at a falling edge
  task automatic put_word(input in_word_t w);
    while (!steady && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w.known_length, w.data_byte};
    in_tuser  <= {w.length_known, w.start_of_string};
    in_tlast  <= w.end_of_data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Drop valid and let the block drain before touching the register
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_prefix(input logic [1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    prefix_now   = v;
  endtask

  // Length fields of non-first bytes are don't-care; randomize them and end_of_data
  task automatic add_byte(input logic [7:0] b);
    in_word_t w;
    w.data_byte       = b;
    w.start_of_string = 1'b0;
    w.length_known    = 1'($urandom);
    w.known_length    = 16'($urandom);
    w.end_of_data     = ($urandom_range(99) < 3);
    field_q = {field_q, w};
  endtask

  // Lay out one string field; each section is capped at 64 characters or bytes, so
  // oversized fields stay open and get abandoned by the next start.
  task automatic build_field(input logic known, input logic [15:0] count,
                             input logic wide, input logic rich, input logic [15:0] runs,
                             input logic phon, input logic [31:0] psize, input int fill);
    logic [7:0] opt;
    in_word_t   w;
    if (!known) begin
      add_byte(count[7:0]);
      if (prefix_now != LFB_ONE_BYTE) add_byte(count[15:8]);
    end
    opt = 8'($urandom) & ~(OPT_BYTE_WIDE | OPT_BYTE_PHON | OPT_BYTE_RICH);
    if (wide) opt |= OPT_BYTE_WIDE;
    if (phon) opt |= OPT_BYTE_PHON;
    if (rich) opt |= OPT_BYTE_RICH;
    add_byte(opt);
    if (rich) begin
      add_byte(runs[7:0]);
      add_byte(runs[15:8]);
    end
    if (phon)
      for (int i = 0; i < 4; i++) add_byte(psize[8*i +: 8]);
    for (int i = 0; i < count && i < 64; i++) begin
      add_byte(fill < 0 ? 8'($urandom) : 8'(fill));
      if (wide) add_byte(fill < 0 ? 8'($urandom) : 8'(fill));
    end
    if (rich)
      for (int i = 0; i < 4 * runs && i < 64; i++) add_byte(8'($urandom));
    if (phon && !psize[31])
      for (int i = 0; i < psize && i < 64; i++) add_byte(8'($urandom));
    w                 = field_q[0];
    w.start_of_string = 1'b1;
    w.length_known    = known;
    w.known_length    = known ? count : 16'($urandom);
    field_q[0]        = w;
  endtask

  // Send the laid-out field, optionally cut short, optionally marking end of data
  task automatic send_field(input logic eod_last, input int cut);
    in_word_t w;
    while (cut > 0 && field_q.size() > cut) void'(field_q.pop_back());
    if (eod_last) begin
      w             = field_q[field_q.size()-1];
      w.end_of_data = 1'b1;
      field_q[field_q.size()-1] = w;
    end
    foreach (field_q[i]) put_word(field_q[i]);
    field_words += field_q.size();
    field_q.delete();
  endtask

  task automatic random_field();
    int          pick;
    int          cut;
    logic        known, wide, rich, phon, eod_last;
    logic [15:0] count, runs;
    logic [31:0] psize;
    in_word_t    w;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // noise word: anything may start or feed a field
      w.data_byte       = 8'($urandom);
      w.start_of_string = 1'($urandom);
      w.length_known    = 1'($urandom);
      w.known_length    = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(6));
      w.end_of_data     = 1'($urandom);
      put_word(w);
      field_words++;
    end else if (pick < 10) begin
      // stray byte outside a field; ignored unless a field is open
      w             = '0;
      w.data_byte   = 8'($urandom);
      w.end_of_data = 1'($urandom);
      put_word(w);
    end else begin
      known = ($urandom_range(99) < 25);
      pick  = $urandom_range(99);
      if (pick < 15)      count = 16'd0;
      else if (pick < 90) count = 16'($urandom_range(8, 1));
      else                count = 16'($urandom_range(40, 9));
      wide  = 1'($urandom);
      rich  = ($urandom_range(99) < 30);
      runs  = 16'($urandom_range(3));
      phon  = ($urandom_range(99) < 30);
      pick  = $urandom_range(99);
      if (pick < 60)      psize = 32'($urandom_range(5));
      else if (pick < 80) psize = 32'd0;
      else                psize = {1'b1, 31'($urandom)};
      eod_last = ($urandom_range(99) < 30);
      build_field(known, count, wide, rich, runs, phon, psize, -1);
      cut = 0;
      if ($urandom_range(99) < 8) cut = $urandom_range(field_q.size() - 1, 1);
      // empty count right at the end of the data
      if (count == 0 && !known && $urandom_range(99) < 25) begin
        cut      = (prefix_now == LFB_ONE_BYTE) ? 1 : 2;
        eod_last = 1'b1;
      end
      send_field(eod_last, cut);
    end
  endtask

  initial begin
    logic [1:0] settings [4];
    int         start_words;
    settings = '{LFB_ONE_BYTE, 2'd0, 2'd3, LFB_RESET};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_prefix(LFB_RESET);

    // Directed: empty fields at the end of data and otherwise
    build_field(1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b1, 2);
    build_field(1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b1, 0);
    build_field(1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b0, 0);
    build_field(1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b1, 0);
    // Directed: character extremes, narrow and wide
    build_field(1'b1, 16'd2, 1'b0, 1'b0, 16'd0, 1'b0, 32'd0, 8'hFF);
    send_field(1'b0, 0);
    build_field(1'b0, 16'd2, 1'b1, 1'b0, 16'd0, 1'b0, 32'd0, 8'hFF);
    send_field(1'b0, 0);
    build_field(1'b1, 16'd3, 1'b1, 1'b0, 16'd0, 1'b0, 32'd0, 8'h00);
    send_field(1'b0, 0);
    // Directed: trailers, negative phonetic size, empty trailers
    build_field(1'b0, 16'd1, 1'b1, 1'b1, 16'd1, 1'b1, 32'd2, -1);
    send_field(1'b0, 0);
    build_field(1'b0, 16'd2, 1'b0, 1'b0, 16'd0, 1'b1, 32'h8000_0005, -1);
    send_field(1'b0, 0);
    build_field(1'b0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b0, 0);
    build_field(1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b1, 32'd0, -1);
    send_field(1'b0, 0);
    // Directed: maximal sizes, abandoned by the next start
    build_field(1'b1, 16'hFFFF, 1'b0, 1'b0, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b0, 5);
    build_field(1'b0, 16'hFFFF, 1'b1, 1'b0, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b0, 6);
    build_field(1'b0, 16'd1, 1'b0, 1'b1, 16'hFFFF, 1'b0, 32'd0, -1);
    send_field(1'b0, 10);
    build_field(1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b1, 32'h7FFF_FFFF, -1);
    send_field(1'b1, 9);
    build_field(1'b0, 16'd1, 1'b0, 1'b0, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b0, 0);
    // Directed: one-byte count, empty at end of data, then a short field
    set_prefix(LFB_ONE_BYTE);
    build_field(1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b1, 1);
    build_field(1'b0, 16'd5, 1'b0, 1'b0, 16'd0, 1'b0, 32'd0, -1);
    send_field(1'b1, 0);

    // Random fields, one batch per register setting
    foreach (settings[k]) begin
      set_prefix(settings[k]);
      if (k == 1) hold_request <= 1'b1;
      start_words = field_words;
      while (field_words - start_words < RANDOM_WORDS / 4) begin
        // no idling through the middle of the third batch
        if (k == 2) steady <= (field_words - start_words > 60 &&
                               field_words - start_words < 280);
        random_field();
      end
      steady <= 1'b0;
    end

    wait_idle();
    repeat (8) @(negedge clk);
    $display("Sent %0d words (%0d in fields or noise), checked %0d result words",
             words_sent, field_words, results_checked);
    $display("Covered count prefix settings 0..3, known lengths, rich and phonetic trailers,");
    $display("empty, truncated and abandoned fields, with a long result-side hold-off");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/b8usp_pkg.sv
rtl/core/b8usp_core.sv
rtl/core/biff8_unicode_string_parser_unit.sv
tb/sv/biff8_string_checker.sv
tb/sv/biff8_unicode_string_parser_unit_tb.sv
